>>> hw/rtl/lav_pkg.sv
// Shared types and constants for the look-at view matrix core.
// Holds the request and response words and the sideband carried through the pipeline.
// No dependencies.
`default_nettype none

package lav_pkg;

   localparam int FIX_W   = 32;
   localparam int UNIT_W  = 18;
   localparam int WIDE_W  = 52;
   localparam int PROD_W  = 50;
   localparam int MAG_W   = 52;
   localparam int MSB_W   = 6;
   localparam int NM_W    = 31;
   localparam int SQ_W    = 62;
   localparam int SUM_W   = 64;
   localparam int ROOT_W  = 32;
   localparam int QUO_W   = 17;
   localparam int FRAC_W  = 16;
   localparam int REM_W   = NM_W + FRAC_W + 1;
   localparam int SQRT_PER_STAGE = 2;
   localparam int SQRT_STAGES    = 16;
   localparam int DIV_STAGES     = QUO_W;

   typedef logic signed [FIX_W-1:0]  lav_fix_type;
   typedef logic signed [UNIT_W-1:0] lav_unit_type;
   typedef logic signed [WIDE_W-1:0] lav_wide_type;

   typedef lav_fix_type  [2:0] lav_fvec_type;
   typedef lav_unit_type [2:0] lav_uvec_type;
   typedef lav_wide_type [2:0] lav_wvec_type;

   typedef struct packed {
      lav_fvec_type eye;
      lav_fvec_type up;
      lav_uvec_type w;
      lav_uvec_type u;
   } lav_side_type;

   typedef struct packed {
      logic [FIX_W-1:0] eye_x;
      logic [FIX_W-1:0] eye_y;
      logic [FIX_W-1:0] eye_z;
      logic [FIX_W-1:0] target_x;
      logic [FIX_W-1:0] target_y;
      logic [FIX_W-1:0] target_z;
      logic [FIX_W-1:0] up_x;
      logic [FIX_W-1:0] up_y;
      logic [FIX_W-1:0] up_z;
   } lav_req_type;

   typedef struct packed {
      logic [FIX_W-1:0] right_x;
      logic [FIX_W-1:0] right_y;
      logic [FIX_W-1:0] right_z;
      logic [FIX_W-1:0] right_shift;
      logic [FIX_W-1:0] upward_x;
      logic [FIX_W-1:0] upward_y;
      logic [FIX_W-1:0] upward_z;
      logic [FIX_W-1:0] upward_shift;
      logic [FIX_W-1:0] forward_x;
      logic [FIX_W-1:0] forward_y;
      logic [FIX_W-1:0] forward_z;
      logic [FIX_W-1:0] forward_shift;
   } lav_rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/lav_norm.sv
// Pipelined 3-vector normalizer: range scaling, sum of squares, digit-recurrence
// square root and restoring division, all stages sharing one advance enable.
// Depends on lav_pkg.
`default_nettype none

module lav_norm import lav_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire lav_wvec_type in_vec,
   input  wire lav_side_type in_side,
   output      logic         out_valid,
   output      lav_uvec_type out_vec,
   output      lav_side_type out_side
);

   typedef struct packed {
      logic                       valid;
      logic [2:0]                 neg;
      logic [2:0][MAG_W-1:0]      mag;
      logic [MAG_W-1:0]           orv;
      lav_side_type               side;
   } a_type;

   typedef struct packed {
      logic                       valid;
      logic [2:0]                 neg;
      logic                       zero;
      logic [MSB_W-1:0]           msb;
      logic [2:0][MAG_W-1:0]      mag;
      lav_side_type               side;
   } b_type;

   typedef struct packed {
      logic                       valid;
      logic [2:0]                 neg;
      logic                       zero;
      logic [2:0][NM_W-1:0]       nm;
      lav_side_type               side;
   } c_type;

   typedef struct packed {
      logic                       valid;
      logic [2:0]                 neg;
      logic                       zero;
      logic [2:0][NM_W-1:0]       nm;
      logic [2:0][SQ_W-1:0]       sq;
      lav_side_type               side;
   } d_type;

   typedef struct packed {
      logic                       valid;
      logic [2:0]                 neg;
      logic                       zero;
      logic [2:0][NM_W-1:0]       nm;
      logic [SUM_W-1:0]           n;
      logic [SUM_W-1:0]           r;
      lav_side_type               side;
   } r_type;

   typedef struct packed {
      logic                       valid;
      logic [2:0]                 neg;
      logic                       zero;
      logic [ROOT_W-1:0]          len;
      logic [2:0][REM_W-1:0]      rem;
      logic [2:0][QUO_W-1:0]      q;
      lav_side_type               side;
   } q_type;

   typedef struct packed {
      logic                       valid;
      lav_uvec_type               vec;
      lav_side_type               side;
   } o_type;

   a_type a_in, a_ff;
   b_type b_in, b_ff;
   c_type c_in, c_ff;
   d_type d_in, d_ff;
   r_type r_in0;
   r_type r_ff [0:SQRT_STAGES];
   q_type q_in0;
   q_type q_ff [0:DIV_STAGES];
   o_type o_in, o_ff;

   // magnitudes and sign
   always_comb begin
      a_in.valid = in_valid;
      a_in.side  = in_side;
      for (int i = 0; i < 3; i++) begin
         a_in.neg[i] = in_vec[i][WIDE_W-1];
         a_in.mag[i] = a_in.neg[i] ? MAG_W'(-$signed(in_vec[i])) : MAG_W'(in_vec[i]);
      end
      a_in.orv = a_in.mag[0] | a_in.mag[1] | a_in.mag[2];
   end

   // leading one of the largest magnitude
   always_comb begin
      b_in.valid = a_ff.valid;
      b_in.neg   = a_ff.neg;
      b_in.mag   = a_ff.mag;
      b_in.side  = a_ff.side;
      b_in.zero  = (a_ff.orv == '0);
      b_in.msb   = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (a_ff.orv[i]) begin
            b_in.msb = MSB_W'(i);
         end
      end
   end

   // scale so the largest magnitude lands in [2^30, 2^31)
   always_comb begin
      c_in.valid = b_ff.valid;
      c_in.neg   = b_ff.neg;
      c_in.zero  = b_ff.zero;
      c_in.side  = b_ff.side;
      for (int i = 0; i < 3; i++) begin
         if (b_ff.msb > MSB_W'(NM_W - 1)) begin
            c_in.nm[i] = NM_W'(b_ff.mag[i] >> (b_ff.msb - MSB_W'(NM_W - 1)));
         end else begin
            c_in.nm[i] = NM_W'(b_ff.mag[i] << (MSB_W'(NM_W - 1) - b_ff.msb));
         end
      end
   end

   always_comb begin
      d_in.valid = c_ff.valid;
      d_in.neg   = c_ff.neg;
      d_in.zero  = c_ff.zero;
      d_in.nm    = c_ff.nm;
      d_in.side  = c_ff.side;
      for (int i = 0; i < 3; i++) begin
         d_in.sq[i] = SQ_W'(c_ff.nm[i]) * SQ_W'(c_ff.nm[i]);
      end
   end

   always_comb begin
      r_in0.valid = d_ff.valid;
      r_in0.neg   = d_ff.neg;
      r_in0.zero  = d_ff.zero;
      r_in0.nm    = d_ff.nm;
      r_in0.side  = d_ff.side;
      r_in0.n     = SUM_W'(d_ff.sq[0]) + SUM_W'(d_ff.sq[1]) + SUM_W'(d_ff.sq[2]);
      r_in0.r     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid  <= 1'b0;
         b_ff.valid  <= 1'b0;
         c_ff.valid  <= 1'b0;
         d_ff.valid  <= 1'b0;
         r_ff[0].valid <= 1'b0;
         q_ff[0].valid <= 1'b0;
         o_ff.valid  <= 1'b0;
      end else if (en) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
         d_ff    <= d_in;
         r_ff[0] <= r_in0;
         q_ff[0] <= q_in0;
         o_ff    <= o_in;
      end
   end

   // square root, two result bits per stage
   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      r_type r_in;
      always_comb begin : step
         logic [SUM_W-1:0] bitv;
         r_in = r_ff[k];
         for (int s = 0; s < SQRT_PER_STAGE; s++) begin
            bitv = SUM_W'(1) << (SUM_W - 2 - 2 * (SQRT_PER_STAGE * k + s));
            if (r_in.n >= r_in.r + bitv) begin
               r_in.n = r_in.n - (r_in.r + bitv);
               r_in.r = (r_in.r >> 1) + bitv;
            end else begin
               r_in.r = r_in.r >> 1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            r_ff[k+1].valid <= 1'b0;
         end else if (en) begin
            r_ff[k+1] <= r_in;
         end
      end
   end

   always_comb begin
      q_in0.valid = r_ff[SQRT_STAGES].valid;
      q_in0.neg   = r_ff[SQRT_STAGES].neg;
      q_in0.zero  = r_ff[SQRT_STAGES].zero;
      q_in0.side  = r_ff[SQRT_STAGES].side;
      q_in0.len   = r_ff[SQRT_STAGES].r[ROOT_W-1:0];
      q_in0.q     = '0;
      for (int i = 0; i < 3; i++) begin
         q_in0.rem[i] = REM_W'(r_ff[SQRT_STAGES].nm[i]) << FRAC_W;
      end
   end

   // restoring division, one quotient bit per stage for all three lanes
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      q_type q_in;
      always_comb begin : step
         logic [REM_W:0] trial;
         q_in  = q_ff[j];
         trial = (REM_W + 1)'(q_ff[j].len) << (QUO_W - 1 - j);
         for (int i = 0; i < 3; i++) begin
            if ({1'b0, q_ff[j].rem[i]} >= trial) begin
               q_in.rem[i] = REM_W'({1'b0, q_ff[j].rem[i]} - trial);
               q_in.q[i][QUO_W-1-j] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            q_ff[j+1].valid <= 1'b0;
         end else if (en) begin
            q_ff[j+1] <= q_in;
         end
      end
   end

   always_comb begin
      o_in.valid = q_ff[DIV_STAGES].valid;
      o_in.side  = q_ff[DIV_STAGES].side;
      for (int i = 0; i < 3; i++) begin
         if (q_ff[DIV_STAGES].zero) begin
            o_in.vec[i] = '0;
         end else if (q_ff[DIV_STAGES].neg[i]) begin
            o_in.vec[i] = -$signed({1'b0, q_ff[DIV_STAGES].q[i]});
         end else begin
            o_in.vec[i] = $signed({1'b0, q_ff[DIV_STAGES].q[i]});
         end
      end
   end

   assign out_valid = o_ff.valid;
   assign out_vec   = o_ff.vec;
   assign out_side  = o_ff.side;

endmodule

`default_nettype wire

>>> hw/rtl/look_at_view_matrix_core.sv
// Look-at view matrix core: top level with difference, cross, dot and saturation stages.
// Depends on lav_pkg and lav_norm.
//
// Usage:
//  - req channel: one word holds eye, target and up, each signed Q16.16.
//  - rsp channel: one word holds the right, upward and forward rows of the view
//    matrix, each as three unit components in Q16.16 and a saturated translation.
//  - A word is taken when valid and ready are both high on a rising clock edge.
//  - Throughput: one word per cycle while rsp_ready stays high, with no gaps between items.
//  - Each of the three normalizations is a 40-stage pipeline (range scaling,
//    squares, a 32-bit square root at two bits per stage, then a 17-bit
//    restoring divide).
//  - All stages advance together whenever the output register is empty or is
//    being taken; a stalled receiver freezes every stage and drops req_ready,
//    so nothing is lost or repeated.
//  - Reset (synchronous, active high) clears every stage valid bit; the
//    pipeline is ready in the first cycle after reset.
//  - A zero-length vector normalizes to zero, so target equal to eye gives zero rows,
//    and up parallel to the view direction gives zero right and upward rows.
`default_nettype none

module look_at_view_matrix_core import lav_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire lav_req_type req_word,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      lav_rsp_type rsp_word
);

   typedef struct packed {
      logic         valid;
      lav_wvec_type vec;
      lav_side_type side;
   } vec_type;

   typedef struct packed {
      logic                    valid;
      logic [5:0][PROD_W-1:0]  p;
      lav_side_type            side;
   } prod_type;

   typedef struct packed {
      logic                    valid;
      logic [8:0][PROD_W-1:0]  p;
      lav_uvec_type            v;
      lav_side_type            side;
   } dot_type;

   typedef struct packed {
      logic                    valid;
      logic [2:0][WIDE_W-1:0]  s;
      lav_uvec_type            v;
      lav_side_type            side;
   } sum_type;

   typedef struct packed {
      logic        valid;
      lav_rsp_type word;
   } out_type;

   logic         en;
   vec_type      dif_in, dif_ff;
   prod_type     x1_in, x1_ff, x3_in, x3_ff;
   vec_type      x2_in, x2_ff, x4_in, x4_ff;
   dot_type      dt_in, dt_ff;
   sum_type      sm_in, sm_ff;
   out_type      out_in, out_ff;

   logic         n1_valid, n2_valid, n3_valid;
   lav_uvec_type n1_vec, n2_vec, n3_vec;
   lav_side_type n1_side, n2_side, n3_side;

   assign en        = !out_ff.valid || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = out_ff.valid;
   assign rsp_word  = out_ff.word;

   always_comb begin
      dif_in.valid       = req_valid;
      dif_in.side.eye[0] = req_word.eye_x;
      dif_in.side.eye[1] = req_word.eye_y;
      dif_in.side.eye[2] = req_word.eye_z;
      dif_in.side.up[0]  = req_word.up_x;
      dif_in.side.up[1]  = req_word.up_y;
      dif_in.side.up[2]  = req_word.up_z;
      dif_in.side.w      = '0;
      dif_in.side.u      = '0;
      dif_in.vec[0] = WIDE_W'($signed(req_word.target_x)) - WIDE_W'($signed(req_word.eye_x));
      dif_in.vec[1] = WIDE_W'($signed(req_word.target_y)) - WIDE_W'($signed(req_word.eye_y));
      dif_in.vec[2] = WIDE_W'($signed(req_word.target_z)) - WIDE_W'($signed(req_word.eye_z));
   end

   lav_norm u_norm_w (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (dif_ff.valid),
      .in_vec   (dif_ff.vec),
      .in_side  (dif_ff.side),
      .out_valid(n1_valid),
      .out_vec  (n1_vec),
      .out_side (n1_side)
   );

   // up x w
   always_comb begin
      x1_in.valid  = n1_valid;
      x1_in.side   = n1_side;
      x1_in.side.w = n1_vec;
      x1_in.p[0] = $signed(n1_side.up[1]) * $signed(n1_vec[2]);
      x1_in.p[1] = $signed(n1_side.up[2]) * $signed(n1_vec[1]);
      x1_in.p[2] = $signed(n1_side.up[2]) * $signed(n1_vec[0]);
      x1_in.p[3] = $signed(n1_side.up[0]) * $signed(n1_vec[2]);
      x1_in.p[4] = $signed(n1_side.up[0]) * $signed(n1_vec[1]);
      x1_in.p[5] = $signed(n1_side.up[1]) * $signed(n1_vec[0]);
   end

   always_comb begin
      x2_in.valid = x1_ff.valid;
      x2_in.side  = x1_ff.side;
      for (int i = 0; i < 3; i++) begin
         x2_in.vec[i] = $signed(x1_ff.p[2*i]) - $signed(x1_ff.p[2*i+1]);
      end
   end

   lav_norm u_norm_u (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (x2_ff.valid),
      .in_vec   (x2_ff.vec),
      .in_side  (x2_ff.side),
      .out_valid(n2_valid),
      .out_vec  (n2_vec),
      .out_side (n2_side)
   );

   // w x u
   always_comb begin
      x3_in.valid  = n2_valid;
      x3_in.side   = n2_side;
      x3_in.side.u = n2_vec;
      x3_in.p[0] = $signed(n2_side.w[1]) * $signed(n2_vec[2]);
      x3_in.p[1] = $signed(n2_side.w[2]) * $signed(n2_vec[1]);
      x3_in.p[2] = $signed(n2_side.w[2]) * $signed(n2_vec[0]);
      x3_in.p[3] = $signed(n2_side.w[0]) * $signed(n2_vec[2]);
      x3_in.p[4] = $signed(n2_side.w[0]) * $signed(n2_vec[1]);
      x3_in.p[5] = $signed(n2_side.w[1]) * $signed(n2_vec[0]);
   end

   always_comb begin
      x4_in.valid = x3_ff.valid;
      x4_in.side  = x3_ff.side;
      for (int i = 0; i < 3; i++) begin
         x4_in.vec[i] = $signed(x3_ff.p[2*i]) - $signed(x3_ff.p[2*i+1]);
      end
   end

   lav_norm u_norm_v (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (x4_ff.valid),
      .in_vec   (x4_ff.vec),
      .in_side  (x4_ff.side),
      .out_valid(n3_valid),
      .out_vec  (n3_vec),
      .out_side (n3_side)
   );

   // basis times eye: u in 0..2, v in 3..5, w in 6..8
   always_comb begin
      dt_in.valid = n3_valid;
      dt_in.side  = n3_side;
      dt_in.v     = n3_vec;
      for (int i = 0; i < 3; i++) begin
         dt_in.p[i]   = $signed(n3_side.u[i]) * $signed(n3_side.eye[i]);
         dt_in.p[3+i] = $signed(n3_vec[i])    * $signed(n3_side.eye[i]);
         dt_in.p[6+i] = $signed(n3_side.w[i]) * $signed(n3_side.eye[i]);
      end
   end

   always_comb begin
      sm_in.valid = dt_ff.valid;
      sm_in.side  = dt_ff.side;
      sm_in.v     = dt_ff.v;
      for (int i = 0; i < 3; i++) begin
         sm_in.s[i] = -($signed(dt_ff.p[3*i]) + $signed(dt_ff.p[3*i+1])
                        + $signed(dt_ff.p[3*i+2]));
      end
   end

   function automatic logic [FIX_W-1:0] lav_sat(input logic [WIDE_W-1:0] n);
      logic signed [WIDE_W-1:0] sh;
      sh = $signed(n) >>> FRAC_W;
      if (sh > WIDE_W'(2147483647)) begin
         lav_sat = {1'b0, {(FIX_W-1){1'b1}}};
      end else if (sh < -WIDE_W'(64'sd2147483648)) begin
         lav_sat = {1'b1, {(FIX_W-1){1'b0}}};
      end else begin
         lav_sat = sh[FIX_W-1:0];
      end
   endfunction

   function automatic logic [FIX_W-1:0] lav_ext(input lav_unit_type x);
      lav_ext = FIX_W'($signed(x));
   endfunction

   always_comb begin
      out_in.valid              = sm_ff.valid;
      out_in.word.right_x       = lav_ext(sm_ff.side.u[0]);
      out_in.word.right_y       = lav_ext(sm_ff.side.u[1]);
      out_in.word.right_z       = lav_ext(sm_ff.side.u[2]);
      out_in.word.right_shift   = lav_sat(sm_ff.s[0]);
      out_in.word.upward_x      = lav_ext(sm_ff.v[0]);
      out_in.word.upward_y      = lav_ext(sm_ff.v[1]);
      out_in.word.upward_z      = lav_ext(sm_ff.v[2]);
      out_in.word.upward_shift  = lav_sat(sm_ff.s[1]);
      out_in.word.forward_x     = lav_ext(sm_ff.side.w[0]);
      out_in.word.forward_y     = lav_ext(sm_ff.side.w[1]);
      out_in.word.forward_z     = lav_ext(sm_ff.side.w[2]);
      out_in.word.forward_shift = lav_sat(sm_ff.s[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dif_ff.valid <= 1'b0;
         x1_ff.valid  <= 1'b0;
         x2_ff.valid  <= 1'b0;
         x3_ff.valid  <= 1'b0;
         x4_ff.valid  <= 1'b0;
         dt_ff.valid  <= 1'b0;
         sm_ff.valid  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         dif_ff <= dif_in;
         x1_ff  <= x1_in;
         x2_ff  <= x2_in;
         x3_ff  <= x3_in;
         x4_ff  <= x4_in;
         dt_ff  <= dt_in;
         sm_ff  <= sm_in;
         out_ff <= out_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_fwd_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_word.forward_x) <= 65536 &&
                     $signed(rsp_word.forward_x) >= -65536))
      else $error("forward_x outside unit range");

   a_right_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_word.right_y) <= 65536 &&
                     $signed(rsp_word.right_y) >= -65536))
      else $error("right_y outside unit range");

   a_zero_view: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.forward_x == '0 && rsp_word.forward_y == '0 &&
       rsp_word.forward_z == '0)
      |-> (rsp_word.right_x == '0 && rsp_word.upward_x == '0 &&
           rsp_word.right_shift == '0 && rsp_word.forward_shift == '0))
      else $error("zero view direction with nonzero rows");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while output stalled");

endmodule

`default_nettype wire

>>> tb/look_at_view_matrix_core_tb.sv
// Self-checking testbench for look_at_view_matrix_core.
// Predicts each view-matrix word from eye, target and up and compares it with rsp_word.
// Depends on lav_pkg and the core RTL.
`default_nettype none

module look_at_view_matrix_core_tb;
   import lav_pkg::*;

   localparam int LATENCY     = 127;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   lav_req_type req_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   lav_rsp_type rsp_word;

   lav_rsp_type matrix_queue[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          stimulus_done = 1'b0;
   bit          long_stalls = 1'b0;

   look_at_view_matrix_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint sext32(logic [31:0] x);
      return longint'($signed(x));
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void unit_vector(input longint vin[3], output longint vout[3]);
      logic [63:0] mag[3];
      bit          neg[3];
      logic [63:0] m;
      logic [63:0] sum;
      logic [63:0] len;
      longint      q;
      m = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = vin[i] < 0;
         mag[i] = neg[i] ? 64'(-vin[i]) : 64'(vin[i]);
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         for (int i = 0; i < 3; i++) vout[i] = 0;
         return;
      end
      while (m >= (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
         m = m >> 1;
      end
      while (m < (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
         m = m << 1;
      end
      for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = longint'((mag[i] << 16) / len);
         vout[i] = neg[i] ? -q : q;
      end
   endfunction

   function automatic void cross3(input longint a[3], input longint b[3],
                                  output longint r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic logic [31:0] translation(longint basis[3], longint eye[3]);
      longint n;
      longint s;
      n = -(basis[0] * eye[0] + basis[1] * eye[1] + basis[2] * eye[2]);
      s = n >>> 16;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s[31:0];
   endfunction

   function automatic lav_rsp_type view_matrix(lav_req_type rq);
      longint eye[3], tgt[3], up[3], d[3], w[3], t[3], u[3], v[3];
      lav_rsp_type rs;
      eye = '{sext32(rq.eye_x), sext32(rq.eye_y), sext32(rq.eye_z)};
      tgt = '{sext32(rq.target_x), sext32(rq.target_y), sext32(rq.target_z)};
      up  = '{sext32(rq.up_x), sext32(rq.up_y), sext32(rq.up_z)};
      for (int i = 0; i < 3; i++) d[i] = tgt[i] - eye[i];
      unit_vector(d, w);
      cross3(up, w, t);
      unit_vector(t, u);
      cross3(w, u, t);
      unit_vector(t, v);
      rs.right_x       = u[0][31:0];
      rs.right_y       = u[1][31:0];
      rs.right_z       = u[2][31:0];
      rs.right_shift   = translation(u, eye);
      rs.upward_x      = v[0][31:0];
      rs.upward_y      = v[1][31:0];
      rs.upward_z      = v[2][31:0];
      rs.upward_shift  = translation(v, eye);
      rs.forward_x     = w[0][31:0];
      rs.forward_y     = w[1][31:0];
      rs.forward_z     = w[2][31:0];
      rs.forward_shift = translation(w, eye);
      return rs;
   endfunction

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
   endfunction

   task automatic send_word(lav_req_type rq, bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      matrix_queue.push_back(view_matrix(rq));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (matrix_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_fix();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(0, 20)) - 10) << 16;
         3: return 32'($signed(16'($urandom)));
         default: return $urandom;
      endcase
   endfunction

   function automatic lav_req_type rand_req();
      lav_req_type rq;
      rq = {rand_fix(), rand_fix(), rand_fix(), rand_fix(), rand_fix(), rand_fix(),
            rand_fix(), rand_fix(), rand_fix()};
      case ($urandom_range(0, 15))
         0: {rq.target_x, rq.target_y, rq.target_z} = {rq.eye_x, rq.eye_y, rq.eye_z};
         1: {rq.up_x, rq.up_y, rq.up_z} = '0;
         2: begin
            rq.up_x = rq.target_x - rq.eye_x;
            rq.up_y = rq.target_y - rq.eye_y;
            rq.up_z = rq.target_z - rq.eye_z;
         end
         default: ;
      endcase
      return rq;
   endfunction

   task automatic test_directed();
      logic [31:0] one, mx, mn;
      one = 32'h0001_0000;
      mx  = 32'h7fff_ffff;
      mn  = 32'h8000_0000;
      send_word('0, 1'b0);
      send_word({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, one, 32'd0, one, 32'd0}, 1'b0);
      send_word({one, one, one, one, one, one, 32'd0, one, 32'd0}, 1'b0);
      send_word({32'd0, 32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0, one, 32'd0}, 1'b0);
      send_word({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0, 32'd0}, 1'b0);
      send_word({mn, mn, mn, mx, mx, mx, mx, mn, mx}, 1'b0);
      send_word({mx, mx, mx, mn, mn, mn, mn, mx, mn}, 1'b0);
      send_word({mx, mn, mx, mn, mx, mn, 32'd1, 32'd0, 32'd0}, 1'b0);
      send_word({mn, mx, mx, mx, mn, mn, mn, mn, mn}, 1'b0);
      send_word({mx, 32'd0, 32'd0, mn, 32'd1, 32'd0, 32'd0, mx, 32'd0}, 1'b0);
      send_word({32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0}, 1'b0);
      send_word({32'hffff_ffff, 32'd5, 32'd9, 32'd3, 32'hffff_fff0, 32'd7,
                 mx, mx, mx}, 1'b0);
      send_word({mn, mn, mn, mx, mx, mx, 32'd0, 32'd0, one}, 1'b0);
      drain();
   endtask

   task automatic test_back_to_back();
      for (int i = 0; i < 200; i++) send_word(rand_req(), 1'b1);
      drain();
   endtask

   task automatic test_random_gaps();
      for (int i = 0; i < 1300; i++) begin
         send_word(rand_req(), 1'b0);
         if (i % 400 == 399) long_stalls = ~long_stalls;
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_stalls) begin
         rsp_ready <= ($urandom_range(0, 3) == 0);
      end else begin
         rsp_ready <= ($urandom_range(0, 4) != 0);
      end
   end

   always @(posedge clock) begin
      lav_rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (matrix_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected word %h", rsp_word);
         end else begin
            want = matrix_queue.pop_front();
            if (want !== rsp_word) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h actual %h", want, rsp_word);
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_back_to_back();
      test_random_gaps();
      if (mismatch_count == 0 && matrix_queue.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/lav_pkg.sv
hw/rtl/lav_norm.sv
hw/rtl/look_at_view_matrix_core.sv
tb/look_at_view_matrix_core_tb.sv
